@@ hdl/sq_diff_integral_image_core_defines.svh @@
`ifndef SQ_DIFF_INTEGRAL_IMAGE_CORE_DEFINES_SVH
`define SQ_DIFF_INTEGRAL_IMAGE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SDII_ASSERT(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// next-cycle implication, disabled in reset
`define SDII_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/sdii_pkg.sv @@
package sdii_pkg;
  localparam int ROW_PIXELS = 1024;
  localparam int LANES      = 4;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 2 * PIX_W;
  localparam int GROUPS     = ROW_PIXELS / LANES;
  localparam int COL_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CNT_W      = $clog2(GROUPS + 1);

  typedef logic [PIX_W-1:0]            pix_t;
  typedef logic [SUM_W-1:0]            sum_t;
  typedef logic [SQ_W-1:0]             sq_t;
  typedef logic [LANES-1:0][SUM_W-1:0] lane_sums_t;
  typedef logic [LANES-1:0][SQ_W-1:0]  lane_sq_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             in_range;
    logic             first_row;
    logic             frame_start;
    logic             row_end;
  } grp_ctrl_t;
endpackage

@@ hdl/sq_diff_integral_image_core.sv @@
// channel | direction | tdata (low bit up)                 | tlast    | tuser
// s_*     | in        | src_pixel_0..3, cmp_pixel_0..3     | row_end  | frame_start
// m_*     | out       | sum_0..3                           | row_last | -
//
// One transaction per cycle sustained while m_tready stays high; each passes stage one, then the output register.
// Only the running row sum in the merge stage carries a dependency between groups.
// The line buffer is one RAM word per group, read at accept, written as the group leaves stage one.
// Reset clears control state and the running row sum only; the line buffer is valid only where written.
// s_tready drops only while the output register holds an untaken result.
module sq_diff_integral_image_core (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // src_pixel_0..3, cmp_pixel_0..3
  input  logic [2*sdii_pkg::LANES*sdii_pkg::PIX_W-1:0] s_tdata,
  input  logic                                          s_tlast,
  // frame_start
  input  logic                                          s_tuser,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // sum_0..3
  output logic [sdii_pkg::LANES*sdii_pkg::SUM_W-1:0]   m_tdata,
  output logic                                          m_tlast
);
  import sdii_pkg::*;

  logic [CNT_W-1:0] column_group;
  logic [CNT_W-1:0] column_group_next;
  logic [CNT_W-1:0] col_eff;
  logic             in_first_row;
  logic             in_first_row_next;
  logic             first_eff;
  logic             in_range_eff;
  logic             accept;
  logic             s1_valid;
  logic             s1_move;
  grp_ctrl_t        s1_ctrl;
  lane_sq_t         s1_sq;
  lane_sums_t       ram_q;
  lane_sums_t       above_word;
  lane_sums_t       totals;
  lane_sums_t       fwd_data;
  logic             fwd_valid;
  logic             fwd_hit;

  assign accept   = s_tvalid && s_tready;
  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_move;

  always_comb begin
    col_eff      = s_tuser ? '0 : column_group;
    first_eff    = s_tuser || in_first_row;
    in_range_eff = col_eff < CNT_W'(GROUPS);
    if (s_tlast) begin
      column_group_next = '0;
      in_first_row_next = 1'b0;
    end else begin
      column_group_next = in_range_eff ? col_eff + 1'b1 : col_eff;
      in_first_row_next = first_eff;
    end
    fwd_hit = s1_move && s1_ctrl.in_range && (s1_ctrl.col == col_eff[COL_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_group <= '0;
      in_first_row <= 1'b1;
      s1_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      fwd_valid    <= 1'b0;
    end else begin
      if (accept) begin
        column_group <= column_group_next;
        in_first_row <= in_first_row_next;
        fwd_valid    <= fwd_hit;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl.col         <= col_eff[COL_W-1:0];
      s1_ctrl.in_range    <= in_range_eff;
      s1_ctrl.first_row   <= first_eff;
      s1_ctrl.frame_start <= s_tuser;
      s1_ctrl.row_end     <= s_tlast;
      fwd_data            <= totals;
    end
    if (s1_move) begin
      m_tdata <= totals;
      m_tlast <= s1_ctrl.row_end;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sdii_lane u_lane (
      .clk  (clk),
      .load (accept),
      .src  (s_tdata[i*PIX_W +: PIX_W]),
      .cmp  (s_tdata[(LANES+i)*PIX_W +: PIX_W]),
      .sq   (s1_sq[i])
    );
  end

  sdii_ram #(
    .WIDTH (LANES*SUM_W),
    .DEPTH (GROUPS)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (s1_move && s1_ctrl.in_range),
    .wr_addr (s1_ctrl.col),
    .wr_data (totals),
    .rd_en   (accept),
    .rd_addr (col_eff[COL_W-1:0]),
    .rd_data (ram_q)
  );

  assign above_word = fwd_valid ? fwd_data : ram_q;

  sdii_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_move),
    .ctrl       (s1_ctrl),
    .sq         (s1_sq),
    .above_word (above_word),
    .totals     (totals)
  );
endmodule

@@ hdl/sdii_ram.sv @@
module sdii_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ hdl/sdii_lane.sv @@
module sdii_lane (
  input  logic          clk,
  input  logic          load,
  input  sdii_pkg::pix_t src,
  input  sdii_pkg::pix_t cmp,
  output sdii_pkg::sq_t  sq
);
  import sdii_pkg::*;

  pix_t diff;

  always_comb begin
    diff = (src >= cmp) ? (src - cmp) : (cmp - src);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sq <= sq_t'(diff) * sq_t'(diff);
    end
  end
endmodule

@@ hdl/sdii_merge.sv @@
module sdii_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  sdii_pkg::grp_ctrl_t  ctrl,
  input  sdii_pkg::lane_sq_t   sq,
  input  sdii_pkg::lane_sums_t above_word,
  output sdii_pkg::lane_sums_t totals
);
  import sdii_pkg::*;

  sum_t running;
  sum_t running_next;
  sum_t acc;

  always_comb begin
    acc = ctrl.frame_start ? '0 : running;
    for (int i = 0; i < LANES; i++) begin
      acc = acc + sum_t'(sq[i]);
      totals[i] = acc + ((ctrl.in_range && !ctrl.first_row) ? above_word[i] : '0);
    end
    running_next = ctrl.row_end ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
    end else if (advance) begin
      running <= running_next;
    end
  end
endmodule

@@ hdl/sdii_chk.sv @@
`include "sq_diff_integral_image_core_defines.svh"

module sdii_chk (
  input logic                                        clk,
  input logic                                        rst,
  input logic                                        s_tvalid,
  input logic                                        s_tready,
  input logic                                        m_tvalid,
  input logic                                        m_tready,
  input logic [sdii_pkg::LANES*sdii_pkg::SUM_W-1:0] m_tdata
);
  import sdii_pkg::*;

  `SDII_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `SDII_ASSERT_NEXT(a_data_hold, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
  `SDII_ASSERT(a_stall_cause, clk, rst, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output stall")
  `SDII_ASSERT(a_latency, clk, rst, (s_tvalid && s_tready) |-> ##2 m_tvalid, "transaction did not reach output")
endmodule

bind sq_diff_integral_image_core sdii_chk u_chk (.*);

@@ test/tb_sq_diff_integral_image_core.sv @@
module tb_sq_diff_integral_image_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sdii_pkg::*;

  localparam int IN_W  = 2 * LANES * PIX_W;
  localparam int ITEMS = 1550;

  typedef struct {
    logic [IN_W-1:0] px;
    logic            re;
    logic            fs;
    int              gap;
    bit              drain;
  } group_t;

  typedef struct {
    lane_sums_t sums;
    logic       last;
  } integral_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_W-1:0]          s_tdata = '0;
  logic                     s_tlast = 1'b0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [LANES*SUM_W-1:0]   m_tdata;
  logic                     m_tlast;

  group_t      pixel_groups[$];
  integral_t   pending_sums[$];
  int          groups_in = 0;
  int          groups_out = 0;
  int          n_bad = 0;

  // predictor state
  sum_t        line_buf[ROW_PIXELS];
  sum_t        row_acc = '0;
  int          col_grp = 0;
  logic        top_row = 1'b1;

  // stimulus shadow: column, first-row flag, written prefix of the line buffer
  int          gen_col = 0;
  logic        gen_top = 1'b1;
  int          gen_filled = 0;

  int          rx_wait = 0;
  int          rx_taken = 0;
  bit          rx_busy = 1'b1;
  int unsigned rx_draw;

  sq_diff_integral_image_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic integral_t integrate_group(logic [IN_W-1:0] px, logic fs, logic re);
    integral_t r;
    logic      in_rng;
    sum_t      above;
    int        a;
    int        b;
    int        d;
    int        idx;
    if (fs) begin
      col_grp = 0;
      row_acc = '0;
      top_row = 1'b1;
    end
    in_rng = col_grp < GROUPS;
    for (int i = 0; i < LANES; i++) begin
      a = px[i*PIX_W +: PIX_W];
      b = px[(LANES+i)*PIX_W +: PIX_W];
      d = (a >= b) ? a - b : b - a;
      row_acc = row_acc + sum_t'(d * d);
      idx = col_grp * LANES + i;
      above = '0;
      if (in_rng && !top_row) above = line_buf[idx];
      r.sums[i] = row_acc + above;
      if (in_rng) line_buf[idx] = r.sums[i];
    end
    r.last = re;
    if (re) begin
      row_acc = '0;
      col_grp = 0;
      top_row = 1'b0;
    end else if (in_rng) begin
      col_grp++;
    end
    return r;
  endfunction

  function automatic pix_t pick_pix();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rand_px();
    logic [IN_W-1:0] px;
    for (int i = 0; i < 2 * LANES; i++) px[i*PIX_W +: PIX_W] = pick_pix();
    return px;
  endfunction

  function automatic logic [IN_W-1:0] flat_px(pix_t src, pix_t cmp);
    return {{LANES{cmp}}, {LANES{src}}};
  endfunction

  // end the row early where the next group would read an unwritten line buffer entry
  function automatic logic add_group(logic [IN_W-1:0] px, logic re, logic fs, int gap,
                                     bit drain);
    group_t g;
    int     c;
    logic   top;
    c = fs ? 0 : gen_col;
    top = fs ? 1'b1 : gen_top;
    if (!top && c + 1 < GROUPS && c + 1 >= gen_filled) re = 1'b1;
    if (top && c < GROUPS && c + 1 > gen_filled) gen_filled = c + 1;
    gen_top = re ? 1'b0 : top;
    gen_col = re ? 0 : ((c < GROUPS) ? c + 1 : c);
    g.px = px;
    g.re = re;
    g.fs = fs;
    g.gap = gap;
    g.drain = drain;
    pixel_groups.push_back(g);
    return re;
  endfunction

  function automatic void note_mismatch(string field, logic [SUM_W-1:0] want,
                                        logic [SUM_W-1:0] got);
    n_bad++;
    if (n_bad <= 10) $display("mismatch %s: expected %h, got %h", field, want, got);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pixel_groups.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (pixel_groups[0].gap > 0) begin
        pixel_groups[0].gap = pixel_groups[0].gap - 1;
        s_tvalid <= 1'b0;
      end else if (pixel_groups[0].drain) begin
        if (!s_tvalid && groups_out == groups_in) pixel_groups[0].drain = 1'b0;
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= pixel_groups[0].px;
        s_tlast  <= pixel_groups[0].re;
        s_tuser  <= pixel_groups[0].fs;
        void'(pixel_groups.pop_front());
      end
    end
  end

  // receiver: short random stalls, two long holds to back up the pipeline
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      rx_taken <= rx_taken + 1;
      if (rx_taken == 300 || rx_taken == 1000) begin
        rx_wait  <= 80;
        m_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) rx_busy <= !rx_busy;
        rx_draw = rx_busy ? $urandom_range(0, 5) : 0;
        rx_wait  <= rx_draw;
        m_tready <= (rx_draw == 0);
      end
    end else if (rx_wait > 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin
    integral_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pending_sums.push_back(integrate_group(s_tdata, s_tuser, s_tlast));
        groups_in <= groups_in + 1;
      end
      if (m_tvalid && m_tready) begin
        groups_out <= groups_out + 1;
        if (pending_sums.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result: sums %h last %b", m_tdata, m_tlast);
        end else begin
          want = pending_sums.pop_front();
          for (int i = 0; i < LANES; i++) begin
            if (m_tdata[i*SUM_W +: SUM_W] !== want.sums[i])
              note_mismatch($sformatf("sum_%0d", i), want.sums[i], m_tdata[i*SUM_W +: SUM_W]);
          end
          if (m_tlast !== want.last)
            note_mismatch("row_last", SUM_W'(want.last), SUM_W'(m_tlast));
        end
      end
    end
  end

  initial begin
    int   n;
    int   rows;
    int   w;
    bit   busy;
    bit   fresh;
    bit   drain;
    bit   big_done;
    logic ended;

    for (int i = 0; i < ROW_PIXELS; i++) line_buf[i] = '0;
    big_done = 1'b0;

    // first row straight after reset, no frame start
    void'(add_group(flat_px(8'h00, 8'hff), 1'b0, 1'b0, 0, 1'b0));
    void'(add_group(flat_px(8'hff, 8'h00), 1'b0, 1'b0, 1, 1'b0));
    void'(add_group(rand_px(), 1'b1, 1'b0, 0, 1'b0));
    // rows reading the line buffer
    void'(add_group(flat_px(8'h80, 8'h7f), 1'b0, 1'b0, 2, 1'b0));
    void'(add_group(flat_px(8'ha5, 8'ha5), 1'b0, 1'b0, 0, 1'b0));
    void'(add_group(rand_px(), 1'b1, 1'b0, 0, 1'b0));
    void'(add_group(rand_px(), 1'b1, 1'b0, 3, 1'b0));
    for (int k = 0; k < 5; k++) begin
      ended = add_group(rand_px(), k == 4, 1'b0, 0, 1'b0);
      if (ended) break;
    end
    // one-group frame, then its second row
    void'(add_group(flat_px(8'hff, 8'h00), 1'b1, 1'b1, 0, 1'b1));
    void'(add_group(flat_px(8'h00, 8'hff), 1'b1, 1'b0, 0, 1'b0));
    // frame restarted in the middle of a row
    void'(add_group(rand_px(), 1'b0, 1'b1, 0, 1'b0));
    void'(add_group(rand_px(), 1'b0, 1'b0, 5, 1'b0));
    void'(add_group(rand_px(), 1'b0, 1'b1, 0, 1'b0));
    void'(add_group(rand_px(), 1'b1, 1'b0, 0, 1'b0));
    void'(add_group(rand_px(), 1'b0, 1'b0, 0, 1'b0));
    void'(add_group(rand_px(), 1'b1, 1'b0, 0, 1'b0));

    while (pixel_groups.size() < ITEMS) begin
      busy = $urandom_range(0, 3) != 0;
      if (!big_done && pixel_groups.size() > 500) begin
        // full-width frame with rows running past the line buffer
        big_done = 1'b1;
        for (int r = 0; r < 3; r++) begin
          n = (r == 0) ? GROUPS + 2 : ((r == 1) ? GROUPS + 1 : 3);
          for (int k = 0; k < n; k++)
            void'(add_group(rand_px(), k == n - 1, r == 0 && k == 0, 0, 1'b0));
        end
      end else if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          void'(add_group(rand_px(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                          busy ? $urandom_range(0, 5) : 0, 1'b0));
      end else begin
        rows = $urandom_range(1, 5);
        w = $urandom_range(1, 8);
        fresh = $urandom_range(0, 3) != 0;
        drain = $urandom_range(0, 15) == 0;
        for (int r = 0; r < rows; r++) begin
          n = (r == 0) ? w : $urandom_range(1, w + 2);
          for (int k = 0; k < n; k++) begin
            ended = add_group(rand_px(), k == n - 1, fresh && r == 0 && k == 0,
                              busy ? $urandom_range(0, 5) : 0, drain && r == 0 && k == 0);
            if (ended) break;
          end
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pixel_groups.size() != 0 || s_tvalid) @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_bad == 0 && pending_sums.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
